// ===== design/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats, angle reduction constants, series divisors and the
// rounding helpers used by the transform matrix builder.
// ----------------------------------------------------------------------------
package trs_pkg;

  // Trig values are signed Q1.TRIG_FRAC_BITS
  localparam int TRIG_FRAC_BITS = 16;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int ROT_W          = TRIG_W + 1;

  // Taylor series depth and pipeline lengths
  localparam int SERIES_TERMS = 10;
  localparam int SC_LAT       = 4 * SERIES_TERMS - 1;
  localparam int BK_LAT       = SC_LAT + 4;

  // Queue between front and back
  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);

  // Angle reduction
  localparam int ANG_W = 23;
  localparam int RED_W = 25;
  localparam logic [RED_W-1:0] DEG360   = RED_W'(360 * 65536);
  localparam logic [RED_W-1:0] DEG90    = RED_W'(90 * 65536);
  localparam logic [RED_W-1:0] DEG180   = RED_W'(180 * 65536);
  localparam logic [RED_W-1:0] DEG270   = RED_W'(270 * 65536);
  localparam logic [7:0]       RECIP360 = 8'((64'd1 << 32) / 64'(360 * 65536));
  localparam logic [RED_W-1:0] WRAP_OFS = RED_W'((64'd1 << 31) % 64'(360 * 65536));

  // pi/180 in Q0.32 and one in Q30
  localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;
  localparam logic [32:0] ONE_Q30         = 33'h0_4000_0000;
  localparam int          DIV_SHIFT       = 33;

  typedef logic signed [31:0]       q16_t;
  typedef logic [ANG_W-1:0]         ang_t;
  typedef logic [RED_W-1:0]         red_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic [32:0]              term_t;
  typedef logic signed [33:0]       psum_t;
  typedef logic [30:0]              rad_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
  } vec3_t;

  // Classified item: index 0 pitch, 1 yaw, 2 roll
  typedef struct packed {
    vec3_t           pos;
    vec3_t           scale;
    logic [2:0][1:0] quad;
    logic [2:0][ANG_W-1:0] ang;
  } item_t;

  typedef struct packed {
    trig_t sn;
    trig_t cs;
  } sincos_t;

  // Divisor of the cosine series step k
  function automatic int cos_div(int k);
    return (2 * k + 1) * (2 * k + 2);
  endfunction

  // Divisor of the sine series step k
  function automatic int sin_div(int k);
    return (2 * k + 2) * (2 * k + 3);
  endfunction

  // Product of two trig values, rounded half up
  function automatic trig_t tmul(trig_t a, trig_t b);
    logic signed [2*TRIG_W-1:0] p;
    p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b)
        + ((2*TRIG_W)'(1) <<< (TRIG_FRAC_BITS - 1));
    return trig_t'(p >>> TRIG_FRAC_BITS);
  endfunction

  // Clamp a Q30 series sum to [0, 1] and round to Q1.F
  function automatic trig_t to_trig(psum_t v);
    psum_t c;
    psum_t r;
    if (v < 0) begin
      c = '0;
    end else if (v > psum_t'(ONE_Q30)) begin
      c = psum_t'(ONE_Q30);
    end else begin
      c = v;
    end
    r = (c + (psum_t'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    return trig_t'(r);
  endfunction

endpackage

// ===== design/trs_if.sv =====
// ----------------------------------------------------------------------------
// trs_if: item channels of the transform matrix builder
// Input channel carries one transform, output channel one matrix.
// ----------------------------------------------------------------------------
interface trs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] pitch_deg;
  logic signed [31:0] yaw_deg;
  logic signed [31:0] roll_deg;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, pitch_deg, yaw_deg, roll_deg,
           scale_x, scale_y, scale_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, pitch_deg, yaw_deg, roll_deg,
           scale_x, scale_y, scale_z,
    output ready
  );
endinterface

interface trs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] col0_x;
  logic signed [31:0] col0_y;
  logic signed [31:0] col0_z;
  logic signed [31:0] col1_x;
  logic signed [31:0] col1_y;
  logic signed [31:0] col1_z;
  logic signed [31:0] col2_x;
  logic signed [31:0] col2_y;
  logic signed [31:0] col2_z;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (
    output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
           col2_x, col2_y, col2_z, trans_x, trans_y, trans_z,
    input  ready
  );
  modport sink (
    input  valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
           col2_x, col2_y, col2_z, trans_x, trans_y, trans_z,
    output ready
  );
endinterface

// ===== design/trs_front.sv =====
// ----------------------------------------------------------------------------
// trs_front: input stage and angle classifier
// Reduces each angle modulo 360 degrees in two pipeline stages and splits it
// into a quadrant and an offset inside the quadrant.
// ----------------------------------------------------------------------------
module trs_front import trs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  trs_in_if.sink in_ch,
  output logic   push_valid,
  input  logic   push_ready,
  output item_t  push_item
);

  logic        adv;
  logic        va_r;
  logic        vb_r;
  vec3_t       pos_a_r, scl_a_r, pos_b_r, scl_b_r;
  logic [31:0] u_a_r  [3];
  logic [7:0]  qe_a_r [3];
  red_t        r_b_r  [3];

  q16_t        deg     [3];
  logic [31:0] u       [3];
  logic [39:0] qe_prod [3];
  logic [31:0] r0      [3];
  red_t        r1      [3];
  red_t        rw      [3];
  quad_t       qd      [3];

  // Advance while the last stage is empty or the queue takes its item
  assign adv         = !vb_r || push_ready;
  assign in_ch.ready = adv;
  assign push_valid  = vb_r;

  assign deg[0] = in_ch.pitch_deg;
  assign deg[1] = in_ch.yaw_deg;
  assign deg[2] = in_ch.roll_deg;

  // Bias to unsigned, estimate the quotient by 360 degrees and take the remainder
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i]       = {~deg[i][31], deg[i][30:0]};
      qe_prod[i] = 40'(u[i]) * 40'(RECIP360);
      r0[i]      = u_a_r[i] - 32'(qe_a_r[i]) * 32'(DEG360);
      r1[i]      = (r0[i] >= 32'(DEG360)) ? red_t'(r0[i] - 32'(DEG360)) : red_t'(r0[i]);
    end
  end

  // Remove the bias and split into quadrant and offset
  always_comb begin
    push_item.pos   = pos_b_r;
    push_item.scale = scl_b_r;
    for (int i = 0; i < 3; i++) begin
      rw[i] = (r_b_r[i] >= WRAP_OFS) ? r_b_r[i] - WRAP_OFS
                                     : r_b_r[i] + (DEG360 - WRAP_OFS);
      if (rw[i] >= DEG270) begin
        qd[i]            = QUAD_270;
        push_item.ang[i] = ang_t'(rw[i] - DEG270);
      end else if (rw[i] >= DEG180) begin
        qd[i]            = QUAD_180;
        push_item.ang[i] = ang_t'(rw[i] - DEG180);
      end else if (rw[i] >= DEG90) begin
        qd[i]            = QUAD_90;
        push_item.ang[i] = ang_t'(rw[i] - DEG90);
      end else begin
        qd[i]            = QUAD_0;
        push_item.ang[i] = ang_t'(rw[i]);
      end
      push_item.quad[i] = qd[i];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_ch.valid;
      vb_r <= va_r;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_a_r <= '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z};
      scl_a_r <= '{x: in_ch.scale_x, y: in_ch.scale_y, z: in_ch.scale_z};
      pos_b_r <= pos_a_r;
      scl_b_r <= scl_a_r;
      for (int i = 0; i < 3; i++) begin
        u_a_r[i]  <= u[i];
        qe_a_r[i] <= qe_prod[i][39:32];
        r_b_r[i]  <= r1[i];
      end
    end
  end

endmodule

// ===== design/trs_fifo.sv =====
// ----------------------------------------------------------------------------
// trs_fifo: short queue between front and back
// Flip-flop queue of classified items so each side can stall on its own.
// ----------------------------------------------------------------------------
module trs_fifo import trs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t            mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FQ_AW:0]   cnt_r;
  logic             push, pop;

  assign in_ready  = (cnt_r != (FQ_AW+1)'(FQ_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_r + FQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_r + FQ_AW'(1);
      end
      cnt_r <= cnt_r + (FQ_AW+1)'(push) - (FQ_AW+1)'(pop);
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== design/trs_sincos.sv =====
// ----------------------------------------------------------------------------
// trs_sincos: pipelined sine and cosine of one reduced angle
// Converts degrees to radians, runs the Taylor series one term per four
// stages, rounds to Q1.F and maps the quadrant.
// ----------------------------------------------------------------------------
module trs_sincos import trs_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  quad_t   quad_in,
  input  ang_t    ang_in,
  output sincos_t sc_out
);

  localparam int NL = SERIES_TERMS;

  rad_t    x_lv  [NL];
  quad_t   q_lv  [NL];
  term_t   ts_lv [NL];
  term_t   tc_lv [NL];
  psum_t   ss_lv [NL];
  psum_t   cs_lv [NL];

  logic [49:0] rad_prod;
  psum_t       ss_fin, cs_fin;
  psum_t       ssf_r, csf_r;
  quad_t       qf_r;
  trig_t       s_val, c_val;
  sincos_t     sc_nxt, sc_r;

  assign rad_prod = 50'(ang_in) * 50'(RAD_PER_DEG_Q32);

  // Load the first series terms
  always_ff @(posedge clk) begin
    if (en) begin
      x_lv[0]  <= rad_prod[48:18];
      q_lv[0]  <= quad_in;
      ts_lv[0] <= term_t'(rad_prod[48:18]);
      tc_lv[0] <= ONE_Q30;
      ss_lv[0] <= '0;
      cs_lv[0] <= '0;
    end
  end

  // One series step: accumulate term k and derive term k+1
  for (genvar k = 0; k < NL - 1; k++) begin : g_term
    localparam int          DS = sin_div(k);
    localparam int          DC = cos_div(k);
    localparam logic [32:0] MS = 33'((64'd1 << DIV_SHIFT) / 64'(DS));
    localparam logic [32:0] MC = 33'((64'd1 << DIV_SHIFT) / 64'(DC));

    term_t       ps1_r, pc1_r, vs2_r, vc2_r, vs3_r, vc3_r, qs3_r, qc3_r;
    psum_t       ss1_r, cs1_r, ss2_r, cs2_r, ss3_r, cs3_r;
    rad_t        x1_r, x2_r, x3_r;
    quad_t       q1_r, q2_r, q3_r;
    logic [63:0] mps, mpc, mvs, mvc;
    logic [65:0] mqs, mqc;
    logic [42:0] rs, rc;
    psum_t       ss_add, cs_add;

    always_comb begin
      mps = 64'(ts_lv[k]) * 64'(x_lv[k]);
      mpc = 64'(tc_lv[k]) * 64'(x_lv[k]);
      mvs = 64'(ps1_r) * 64'(x1_r);
      mvc = 64'(pc1_r) * 64'(x1_r);
      mqs = 66'(vs2_r) * 66'(MS);
      mqc = 66'(vc2_r) * 66'(MC);
      rs  = 43'(vs3_r) - 43'(qs3_r) * 43'(DS);
      rc  = 43'(vc3_r) - 43'(qc3_r) * 43'(DC);
      if ((k % 2) == 0) begin
        ss_add = ss_lv[k] + psum_t'(ts_lv[k]);
        cs_add = cs_lv[k] + psum_t'(tc_lv[k]);
      end else begin
        ss_add = ss_lv[k] - psum_t'(ts_lv[k]);
        cs_add = cs_lv[k] - psum_t'(tc_lv[k]);
      end
    end

    // Multiply twice, estimate the quotient, then correct it by one
    always_ff @(posedge clk) begin
      if (en) begin
        ps1_r <= mps[62:30];
        pc1_r <= mpc[62:30];
        ss1_r <= ss_add;
        cs1_r <= cs_add;
        x1_r  <= x_lv[k];
        q1_r  <= q_lv[k];

        vs2_r <= mvs[62:30];
        vc2_r <= mvc[62:30];
        ss2_r <= ss1_r;
        cs2_r <= cs1_r;
        x2_r  <= x1_r;
        q2_r  <= q1_r;

        qs3_r <= mqs[65:33];
        qc3_r <= mqc[65:33];
        vs3_r <= vs2_r;
        vc3_r <= vc2_r;
        ss3_r <= ss2_r;
        cs3_r <= cs2_r;
        x3_r  <= x2_r;
        q3_r  <= q2_r;

        ts_lv[k+1] <= (rs >= 43'(DS)) ? qs3_r + term_t'(1) : qs3_r;
        tc_lv[k+1] <= (rc >= 43'(DC)) ? qc3_r + term_t'(1) : qc3_r;
        ss_lv[k+1] <= ss3_r;
        cs_lv[k+1] <= cs3_r;
        x_lv[k+1]  <= x3_r;
        q_lv[k+1]  <= q3_r;
      end
    end
  end

  // Add the last term
  always_comb begin
    if (((NL - 1) % 2) == 0) begin
      ss_fin = ss_lv[NL-1] + psum_t'(ts_lv[NL-1]);
      cs_fin = cs_lv[NL-1] + psum_t'(tc_lv[NL-1]);
    end else begin
      ss_fin = ss_lv[NL-1] - psum_t'(ts_lv[NL-1]);
      cs_fin = cs_lv[NL-1] - psum_t'(tc_lv[NL-1]);
    end
  end

  // Round and map the quadrant
  always_comb begin
    s_val = to_trig(ssf_r);
    c_val = to_trig(csf_r);
    case (qf_r)
      QUAD_0:   sc_nxt = '{sn: s_val,  cs: c_val};
      QUAD_90:  sc_nxt = '{sn: c_val,  cs: -s_val};
      QUAD_180: sc_nxt = '{sn: -s_val, cs: -c_val};
      QUAD_270: sc_nxt = '{sn: -c_val, cs: s_val};
      default:  sc_nxt = '{sn: s_val,  cs: c_val};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ssf_r <= ss_fin;
      csf_r <= cs_fin;
      qf_r  <= q_lv[NL-1];
      sc_r  <= sc_nxt;
    end
  end

  assign sc_out = sc_r;

endmodule

// ===== design/trs_back.sv =====
// ----------------------------------------------------------------------------
// trs_back: matrix pipeline
// Three sine/cosine pipelines, trig products, rotation entries, scaling with
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module trs_back import trs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  output logic       head_ready,
  input  item_t      head_item,
  trs_out_if.source  out_ch
);

  localparam int PW = ROT_W + 32;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  logic                adv;
  logic [BK_LAT-1:0]   vld_r;
  sincos_t             sc [3];
  vec3_t               scl_r [SC_LAT+2];
  vec3_t               pos_r [BK_LAT];

  trig_t spsy_r, spcy_r, crcy_r, srcy_r, cpsy_r, srcp_r, crcp_r, crsy_r, srsy_r, cpcy_r;
  trig_t sr_r, cr_r, sp_r;
  rot_t                rot_nxt  [9];
  rot_t                rot_r    [9];
  q16_t                scl_sel  [3];
  logic signed [PW-1:0] prod_r  [9];
  q16_t                res_r    [9];

  // Round by F bits and saturate to 32 bits
  function automatic q16_t round_sat(logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + ((PW)'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    if (t > PW'(Q_MAX)) begin
      return Q_MAX;
    end else if (t < PW'(Q_MIN)) begin
      return Q_MIN;
    end
    return q16_t'(t);
  endfunction

  // Whole pipeline moves unless the output item is stalled
  assign adv        = !vld_r[BK_LAT-1] || out_ch.ready;
  assign head_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BK_LAT-2:0], head_valid};
    end
  end

  // Sine and cosine of pitch, yaw and roll
  for (genvar i = 0; i < 3; i++) begin : g_sc
    trs_sincos u_sincos (
      .clk     (clk),
      .en      (adv),
      .quad_in (quad_t'(head_item.quad[i])),
      .ang_in  (head_item.ang[i]),
      .sc_out  (sc[i])
    );
  end

  // Delay scales and positions alongside the series
  always_ff @(posedge clk) begin
    if (adv) begin
      scl_r[0] <= head_item.scale;
      pos_r[0] <= head_item.pos;
      for (int i = 1; i < SC_LAT + 2; i++) begin
        scl_r[i] <= scl_r[i-1];
      end
      for (int i = 1; i < BK_LAT; i++) begin
        pos_r[i] <= pos_r[i-1];
      end
    end
  end

  // Pairwise trig products
  always_ff @(posedge clk) begin
    if (adv) begin
      spsy_r <= tmul(sc[0].sn, sc[1].sn);
      spcy_r <= tmul(sc[0].sn, sc[1].cs);
      crcy_r <= tmul(sc[2].cs, sc[1].cs);
      srcy_r <= tmul(sc[2].sn, sc[1].cs);
      cpsy_r <= tmul(sc[0].cs, sc[1].sn);
      srcp_r <= tmul(sc[2].sn, sc[0].cs);
      crcp_r <= tmul(sc[2].cs, sc[0].cs);
      crsy_r <= tmul(sc[2].cs, sc[1].sn);
      srsy_r <= tmul(sc[2].sn, sc[1].sn);
      cpcy_r <= tmul(sc[0].cs, sc[1].cs);
      sr_r   <= sc[2].sn;
      cr_r   <= sc[2].cs;
      sp_r   <= sc[0].sn;
    end
  end

  // Rotation entries, column by column
  always_comb begin
    rot_nxt[0] = rot_t'(crcy_r) + rot_t'(tmul(sr_r, spsy_r));
    rot_nxt[1] = rot_t'(srcy_r) - rot_t'(tmul(cr_r, spsy_r));
    rot_nxt[2] = -rot_t'(cpsy_r);
    rot_nxt[3] = -rot_t'(srcp_r);
    rot_nxt[4] = rot_t'(crcp_r);
    rot_nxt[5] = -rot_t'(sp_r);
    rot_nxt[6] = rot_t'(crsy_r) - rot_t'(tmul(sr_r, spcy_r));
    rot_nxt[7] = rot_t'(srsy_r) + rot_t'(tmul(cr_r, spcy_r));
    rot_nxt[8] = rot_t'(cpcy_r);
  end

  assign scl_sel[0] = scl_r[SC_LAT+1].x;
  assign scl_sel[1] = scl_r[SC_LAT+1].y;
  assign scl_sel[2] = scl_r[SC_LAT+1].z;

  // Scale each column, then round and saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        rot_r[j]  <= rot_nxt[j];
        prod_r[j] <= PW'(rot_r[j]) * PW'(scl_sel[j / 3]);
        res_r[j]  <= round_sat(prod_r[j]);
      end
    end
  end

  assign out_ch.valid   = vld_r[BK_LAT-1];
  assign out_ch.col0_x  = res_r[0];
  assign out_ch.col0_y  = res_r[1];
  assign out_ch.col0_z  = res_r[2];
  assign out_ch.col1_x  = res_r[3];
  assign out_ch.col1_y  = res_r[4];
  assign out_ch.col1_z  = res_r[5];
  assign out_ch.col2_x  = res_r[6];
  assign out_ch.col2_y  = res_r[7];
  assign out_ch.col2_z  = res_r[8];
  assign out_ch.trans_x = pos_r[BK_LAT-1].x;
  assign out_ch.trans_y = pos_r[BK_LAT-1].y;
  assign out_ch.trans_z = pos_r[BK_LAT-1].z;

endmodule

// ===== design/trs_matrix_builder.sv =====
// Throughput: one item per cycle unless the output stalls; every series
// term, multiply and divide step has its own pipeline stage, so nothing
// is shared between items.
// Reset (rst_n low, synchronous) empties the pipeline and the queue; data
// registers are not cleared and carry no meaning while their valid is low.
// ----------------------------------------------------------------------------
// trs_matrix_builder: translate-rotate-scale matrix builder
// Front classifies angles, a short queue decouples it from the back, which
// builds the twelve non-constant entries of the column-major matrix.
// ----------------------------------------------------------------------------
module trs_matrix_builder import trs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  trs_in_if.sink    in_ch,
  trs_out_if.source out_ch
);

  logic  f_valid, f_ready;
  item_t f_item;
  logic  q_valid, q_ready;
  item_t q_item;

  trs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  trs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  trs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_ready (q_ready),
    .head_item  (q_item),
    .out_ch     (out_ch)
  );

  // A stalled result freezes the back, so the queue must not drain
  a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !(q_valid && q_ready))
    else $error("queue popped while output stalled");

  // Classified angles lie inside one quadrant
  a_angle_in_quadrant: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> ((RED_W'(q_item.ang[0]) < DEG90) && (RED_W'(q_item.ang[1]) < DEG90)
                 && (RED_W'(q_item.ang[2]) < DEG90)))
    else $error("reduced angle outside quadrant");

  // A full queue backpressures the input once the front is loaded
  a_full_queue_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && !f_ready) |-> !in_ch.ready)
    else $error("input taken while front is blocked");

endmodule
